### rtl/sobel_gradient_feature_macros.svh
// ---------------------------------------------------------------------------
// sobel gradient feature assertion macros
// concurrent check helpers used by the block's top-level rtl
// ---------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_FEATURE_MACROS_SVH
`define SOBEL_GRADIENT_FEATURE_MACROS_SVH

// same-cycle implication
`define SGF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sobel gradient feature check failed");

// next-cycle implication
`define SGF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sobel gradient feature check failed");

`endif

### rtl/sgf_pkg.sv
// ---------------------------------------------------------------------------
// sgf_pkg
// shared types and constants of the sobel gradient feature block
// ---------------------------------------------------------------------------
package sgf_pkg;

    localparam int PIX_W    = 8;
    localparam int FW_W     = 7;
    localparam int FH_W     = 13;
    localparam int ROW_W    = 12;
    localparam int GRAD_W   = 11;
    localparam int ABS_W    = 10;
    localparam int Q_W      = 17;
    localparam int MAG_W    = 16;
    localparam int S_W      = 22;
    localparam int ROOT_W   = 28;
    localparam int REM_W    = 31;
    localparam int GX_W     = 25;
    localparam int GP_W     = 51;
    localparam int MP_W     = 57;
    localparam int CFG_IDX_W = 1;

    localparam logic [FH_W-1:0] HEIGHT_MAX = 13'd4096;
    localparam logic [GX_W-1:0] GRAD_BIAS  = 25'd510;
    localparam logic [25:0]     GRAD_RECIP = 26'd33686019;
    localparam int              GRAD_SHIFT = 35;
    localparam logic [28:0]     MAG_RECIP  = 29'd381113216;
    localparam int              MAG_SHIFT  = 40;
    localparam logic [Q_W-1:0]  MAG_SAT    = 17'd32768;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic                     valid;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     last;
    } t_grad;

    typedef struct packed {
        logic signed [Q_W-1:0] qx;
        logic signed [Q_W-1:0] qy;
        logic                  last;
    } t_side;

endpackage

### rtl/sgf_window.sv
// ---------------------------------------------------------------------------
// sgf_window
// line stores, raster counters, 3x3 window and raw sobel gradients
// ---------------------------------------------------------------------------
module sgf_window #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [sgf_pkg::PIX_W-1:0]   i_pixel,
    input  logic [sgf_pkg::FW_W-1:0]    i_frame_width,
    input  logic [sgf_pkg::FH_W-1:0]    i_frame_height,
    output sgf_pkg::t_grad              o_grad
);
    import sgf_pkg::*;

    localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int WIDE = ((CW > FW_W) ? CW : FW_W) + 1;

    logic [PIX_W-1:0] r_upper  [MAX_WIDTH];
    logic [PIX_W-1:0] r_middle [MAX_WIDTH];

    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [WIDE-1:0]  w_clamp, col_next;
    logic [FH_W-1:0]  h_clamp, row_next;
    logic             col_end, row_end, accept;

    logic             r1_v, r1_emit, r1_last;
    logic [CW-1:0]    r1_col;
    logic [PIX_W-1:0] r1_pix, r1_t, r1_m;

    logic [PIX_W-1:0] r_w0, r_w1, r_w2, r_w3, r_w4, r_w5;

    logic                     r2_v, r2_last;
    logic signed [GRAD_W-1:0] r2_gx, r2_gy, n_gx, n_gy;
    logic [ABS_W-1:0]         sum_r, sum_l, sum_t, sum_b;

    assign accept = i_en && i_valid;

    always_comb begin
        priority if (WIDE'(i_frame_width) < WIDE'(3)) begin
            w_clamp = WIDE'(3);
        end else if (WIDE'(i_frame_width) > WIDE'(MAX_WIDTH)) begin
            w_clamp = WIDE'(MAX_WIDTH);
        end else begin
            w_clamp = WIDE'(i_frame_width);
        end
        priority if (i_frame_height < FH_W'(3)) begin
            h_clamp = FH_W'(3);
        end else if (i_frame_height > HEIGHT_MAX) begin
            h_clamp = HEIGHT_MAX;
        end else begin
            h_clamp = i_frame_height;
        end
        col_next = WIDE'(r_col) + WIDE'(1);
        row_next = FH_W'(r_row) + FH_W'(1);
        col_end  = col_next >= w_clamp;
        row_end  = row_next >= h_clamp;
        n_col    = col_end ? '0 : CW'(col_next);
        n_row    = r_row;
        if (col_end) begin
            n_row = row_end ? '0 : ROW_W'(row_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
        end else if (i_en) begin
            r1_v <= accept;
            r2_v <= r1_v && r1_emit;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // line stores: read on accept, write when the item leaves stage one
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_t <= r_upper[r_col];
            r1_m <= r_middle[r_col];
        end
        if (i_en && r1_v) begin
            r_upper[r1_col]  <= r1_m;
            r_middle[r1_col] <= r1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_pix  <= i_pixel;
            r1_col  <= r_col;
            r1_emit <= (r_row >= ROW_W'(2)) && (r_col >= CW'(2));
            r1_last <= row_end && col_end;
        end
    end

    always_comb begin
        sum_r = ABS_W'(r1_t) + ABS_W'({r1_m, 1'b0}) + ABS_W'(r1_pix);
        sum_l = ABS_W'(r_w0) + ABS_W'({r_w1, 1'b0}) + ABS_W'(r_w2);
        sum_t = ABS_W'(r_w0) + ABS_W'({r_w3, 1'b0}) + ABS_W'(r1_t);
        sum_b = ABS_W'(r_w2) + ABS_W'({r_w5, 1'b0}) + ABS_W'(r1_pix);
        n_gx  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
        n_gy  = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0 <= '0;
            r_w1 <= '0;
            r_w2 <= '0;
            r_w3 <= '0;
            r_w4 <= '0;
            r_w5 <= '0;
        end else if (i_en && r1_v) begin
            r_w0 <= r_w3;
            r_w1 <= r_w4;
            r_w2 <= r_w5;
            r_w3 <= r1_t;
            r_w4 <= r1_m;
            r_w5 <= r1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r1_v) begin
            r2_gx   <= n_gx;
            r2_gy   <= n_gy;
            r2_last <= r1_last;
        end
    end

    assign o_grad.valid = r2_v;
    assign o_grad.gx    = r2_gx;
    assign o_grad.gy    = r2_gy;
    assign o_grad.last  = r2_last;

endmodule

### rtl/sgf_isqrt.sv
// ---------------------------------------------------------------------------
// sgf_isqrt
// pipelined square root, one root bit per stage, side data carried along
// ---------------------------------------------------------------------------
module sgf_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [sgf_pkg::S_W-1:0]       i_s,
    input  sgf_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [sgf_pkg::ROOT_W-1:0]    o_root,
    output sgf_pkg::t_side                o_side
);
    import sgf_pkg::*;

    logic              r_v    [ROOT_W+1];
    logic [S_W-1:0]    r_s    [ROOT_W+1];
    logic [REM_W-1:0]  r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    t_side             r_side [ROOT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0]    <= i_s;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  n_rem, trial;
        logic [ROOT_W-1:0] n_root;

        always_comb begin
            n_rem  = {r_rem[k][REM_W-3:0], r_s[k][S_W-1 -: 2]};
            trial  = REM_W'({r_root[k], 2'b01});
            n_root = {r_root[k][ROOT_W-2:0], 1'b0};
            if (n_rem >= trial) begin
                n_rem  = n_rem - trial;
                n_root = {r_root[k][ROOT_W-2:0], 1'b1};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k+1]    <= {r_s[k][S_W-3:0], 2'b00};
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= n_root;
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];

endmodule

### rtl/sobel_gradient_feature.sv
// ---------------------------------------------------------------------------
// sobel_gradient_feature
// 3x3 sobel gradients and magnitude over a raster pixel stream
// ---------------------------------------------------------------------------
// input channel: i_valid / o_stall with i_pixel, one 8-bit pixel per item,
//   raster order, frame size from the frame_width and frame_height registers
// output channel: o_valid / i_stall with gradient_x, gradient_y, magnitude
//   and frame_last; one item per interior pixel, none for border pixels
// config channel: i_cfg_valid / o_cfg_ready, index 0 frame_width,
//   index 1 frame_height; always ready, write only while idle
// register stages: 34 in all (3 window and gradient stages, 29 square root
//   stages, 2 magnitude scaling stages)
// throughput: one item per cycle unless stalled, set by the 1-bit-per-stage
//   square root pipeline and one read plus one write of each line store per
//   pixel
// reset: counters, window and all valid bits clear, registers go to 40x40;
//   line stores hold nothing until the first rows are written
// stall: while the output item is held, the whole pipeline freezes and
//   o_stall rises; no item is dropped or repeated
// ---------------------------------------------------------------------------
`include "sobel_gradient_feature_macros.svh"

module sobel_gradient_feature #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sgf_pkg::PIX_W-1:0]         i_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [sgf_pkg::Q_W-1:0]    o_gradient_x,
    output logic signed [sgf_pkg::Q_W-1:0]    o_gradient_y,
    output logic [sgf_pkg::MAG_W-1:0]         o_magnitude,
    output logic                              o_frame_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sgf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sgf_pkg::FH_W-1:0]          i_cfg_data
);
    import sgf_pkg::*;

    logic            en;
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    t_grad           grad;

    logic                  r3_v, r3_nx, r3_ny, r3_last;
    logic [S_W-1:0]        r3_s;
    logic [GP_W-1:0]       r3_px, r3_py;
    logic [ABS_W-1:0]      ax, ay;
    logic [GX_W-1:0]       xx, xy;
    t_side                 side_in, sq_side, r_m_side;
    logic [Q_W-1:0]        qx_mag, qy_mag;

    logic                  sq_v, r_mv;
    logic [ROOT_W-1:0]     sq_root;
    logic [MP_W-1:0]       r_mp;
    logic [Q_W-1:0]        mq, mh;

    logic                  r_out_v, r_out_last;
    logic signed [Q_W-1:0] r_out_gx, r_out_gy;
    logic [MAG_W-1:0]      r_out_mag;

    assign en          = !r_out_v || !i_stall;
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(40);
            r_frame_height <= FH_W'(40);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:          r_frame_height <= r_frame_height;
            endcase
        end
    end

    sgf_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_valid),
        .i_pixel        (i_pixel),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_grad         (grad)
    );

    // squares and reciprocal products for the gradient scaling
    always_comb begin
        ax = ABS_W'(grad.gx < 0 ? -grad.gx : grad.gx);
        ay = ABS_W'(grad.gy < 0 ? -grad.gy : grad.gy);
        xx = {ax, 15'b0} + GRAD_BIAS;
        xy = {ay, 15'b0} + GRAD_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= grad.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_s    <= S_W'(ax * ax) + S_W'(ay * ay);
            r3_px   <= GP_W'(xx) * GP_W'(GRAD_RECIP);
            r3_py   <= GP_W'(xy) * GP_W'(GRAD_RECIP);
            r3_nx   <= grad.gx < 0;
            r3_ny   <= grad.gy < 0;
            r3_last <= grad.last;
        end
    end

    always_comb begin
        qx_mag       = Q_W'(r3_px >> GRAD_SHIFT);
        qy_mag       = Q_W'(r3_py >> GRAD_SHIFT);
        side_in.qx   = r3_nx ? -$signed(qx_mag) : $signed(qx_mag);
        side_in.qy   = r3_ny ? -$signed(qy_mag) : $signed(qy_mag);
        side_in.last = r3_last;
    end

    sgf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_s     (r3_s),
        .i_side  (side_in),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_mv    <= sq_v;
            r_out_v <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mp     <= MP_W'(sq_root) * MP_W'(MAG_RECIP);
            r_m_side <= sq_side;
        end
    end

    // divide the root by 2885, then halve with rounding and saturate
    always_comb begin
        mq = Q_W'(r_mp >> MAG_SHIFT);
        mh = Q_W'((18'(mq) + 18'd1) >> 1);
        if (mh > MAG_SAT) begin
            mh = MAG_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_gx   <= r_m_side.qx;
            r_out_gy   <= r_m_side.qy;
            r_out_last <= r_m_side.last;
            r_out_mag  <= MAG_W'(mh);
        end
    end

    assign o_valid      = r_out_v;
    assign o_gradient_x = r_out_gx;
    assign o_gradient_y = r_out_gy;
    assign o_magnitude  = r_out_mag;
    assign o_frame_last = r_out_last;

    `SGF_ASSERT_SAME(a_stall_only_when_held, o_stall, o_valid && i_stall)
    `SGF_ASSERT_SAME(a_mag_range, o_valid, o_magnitude <= MAG_W'(32768))
    `SGF_ASSERT_SAME(a_zero_grad_zero_mag,
        o_valid && o_gradient_x == '0 && o_gradient_y == '0, o_magnitude == '0)
    `SGF_ASSERT_NEXT(a_drain_empty, o_valid && !i_stall && !r_mv, !o_valid)

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the sobel gradient feature block: frames of pixels,
// some cut short, are streamed in under several frame sizes, each result is
// compared with a bit-exact model of the gradients and magnitude in the bench
// ---------------------------------------------------------------------------
module tb_top;
    import sgf_pkg::*;

    localparam int MAX_W      = 64;
    localparam int DRAIN_WAIT = 40;
    localparam int HOLD_LEN   = 300;
    localparam int WDOG_LIMIT = 2000;
    localparam int RAND_ITEMS = 1000;

    typedef struct {
        logic [Q_W-1:0]   gx;
        logic [Q_W-1:0]   gy;
        logic [MAG_W-1:0] mag;
        logic             last;
    } t_sobel_out;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        bit               typed;
        logic [Q_W-1:0]   gx;
        logic [Q_W-1:0]   gy;
        logic             last;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [PIX_W-1:0]     i_pixel = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [Q_W-1:0] o_gradient_x;
    logic signed [Q_W-1:0] o_gradient_y;
    logic [MAG_W-1:0]     o_magnitude;
    logic                 o_frame_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FH_W-1:0]      i_cfg_data = '0;

    sobel_gradient_feature u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_pixel(i_pixel),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_gradient_x(o_gradient_x), .o_gradient_y(o_gradient_y),
        .o_magnitude(o_magnitude), .o_frame_last(o_frame_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // model state
    logic [FW_W-1:0]  mdl_width;
    logic [FH_W-1:0]  mdl_height;
    logic [PIX_W-1:0] mdl_upper [MAX_W];
    logic [PIX_W-1:0] mdl_middle [MAX_W];
    logic [PIX_W-1:0] mdl_win [6];
    int unsigned      mdl_col;
    int unsigned      mdl_row;

    t_sobel_out pending_results [$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  hold_req = 0;
    int  rand_items = 0;

    function automatic longint unsigned int_sqrt(longint unsigned t);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > t) b = b >> 2;
        while (b != 0) begin
            if (t >= res + b) begin
                t = t - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [Q_W-1:0] grad_q15(int g);
        int unsigned a, q;
        a = (g < 0) ? -g : g;
        q = (a * 32768 + 510) / 1020;
        return (g < 0) ? Q_W'(18'h20000 - q) : Q_W'(q);
    endfunction

    function automatic logic [MAG_W-1:0] mag_q15(int gx, int gy);
        longint unsigned s, r, q;
        s = longint'(gx) * gx + longint'(gy) * gy;
        r = int_sqrt(s << 34);
        q = (r / 2885 + 1) / 2;
        if (q > 32768) q = 32768;
        return MAG_W'(q);
    endfunction

    function automatic int eff_width();
        int w;
        w = mdl_width;
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = mdl_height;
        if (h < 3) h = 3;
        if (h > 4096) h = 4096;
        return h;
    endfunction

    // advance the window for one accepted pixel, return 1 if a result is due
    function automatic bit sobel_predict(logic [PIX_W-1:0] pix, output t_sobel_out res);
        int unsigned w, h, c, r;
        int t0, m0, b0, t1, b1, t2, m2, b2, gx, gy;
        bit hit;
        w = eff_width();
        h = eff_height();
        c = (mdl_col >= MAX_W) ? MAX_W - 1 : mdl_col;
        r = mdl_row;
        t2 = mdl_upper[c];
        m2 = mdl_middle[c];
        b2 = pix;
        mdl_upper[c] = PIX_W'(m2);
        mdl_middle[c] = pix;
        t0 = mdl_win[0]; m0 = mdl_win[1]; b0 = mdl_win[2];
        t1 = mdl_win[3]; b1 = mdl_win[5];
        hit = (r >= 2 && c >= 2);
        gx = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
        gy = (t0 + 2 * t1 + t2) - (b0 + 2 * b1 + b2);
        res.gx = grad_q15(gx);
        res.gy = grad_q15(gy);
        res.mag = mag_q15(gx, gy);
        res.last = (r + 1 >= h && c + 1 >= w);
        mdl_win[0] = mdl_win[3]; mdl_win[1] = mdl_win[4]; mdl_win[2] = mdl_win[5];
        mdl_win[3] = PIX_W'(t2); mdl_win[4] = PIX_W'(m2); mdl_win[5] = pix;
        if (c + 1 >= w) begin
            mdl_col = 0;
            mdl_row = (r + 1 >= h) ? 0 : ((r + 1) & 12'hFFF);
        end else begin
            mdl_col = (c + 1) & 6'h3F;
        end
        return hit;
    endfunction

    task automatic send_pixel(logic [PIX_W-1:0] pix, bit typed, t_dir_row row);
        t_sobel_out res;
        int gap, sel;
        i_valid <= 1'b1;
        i_pixel <= pix;
        forever begin
            @(negedge i_clk);
            if (!o_stall) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        if (sobel_predict(pix, res)) begin
            if (typed) begin
                res.gx = row.gx;
                res.gy = row.gy;
                res.last = row.last;
            end
            pending_results.insert(pending_results.size(), res);
        end
        sel = $urandom_range(0, 99);
        gap = (sel < 60) ? 0 : (sel < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FH_W-1:0] data);
        i_valid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        if (idx == REG_FRAME_WIDTH) mdl_width = data[FW_W-1:0];
        else mdl_height = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic send_frames(int nframes, bit count_rand);
        t_dir_row none;
        int n, mode, base;
        logic [PIX_W-1:0] p;
        none = '{default: '0};
        for (int f = 0; f < nframes; f++) begin
            mode = $urandom_range(0, 9);
            base = $urandom_range(0, 255);
            n = eff_width() * eff_height();
            for (int k = 0; k < n; k++) begin
                case (mode)
                    0: p = PIX_W'(base);
                    1, 2: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    3: p = PIX_W'(base + k);
                    default: p = PIX_W'($urandom_range(0, 255));
                endcase
                send_pixel(p, 1'b0, none);
                if (count_rand) rand_items++;
            end
        end
    endtask

    // receiver stall pattern
    initial begin
        int len, sel;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 10) begin
                    i_stall <= 1'b0;
                    len = $urandom_range(20, 80);
                end else if (sel < 15) begin
                    i_stall <= 1'b1;
                    len = $urandom_range(10, 40);
                end else begin
                    i_stall <= $urandom_range(0, 2) == 0;
                    len = $urandom_range(1, 3);
                end
                repeat (len - 1) @(posedge i_clk);
            end
        end
    end

    // result checker
    initial begin
        t_sobel_out exp_r;
        forever begin
            @(negedge i_clk);
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected item gx=%h gy=%h mag=%0d last=%b", $time,
                        o_gradient_x, o_gradient_y, o_magnitude, o_frame_last);
                    fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_gradient_x !== exp_r.gx) begin
                        $display("%0t: gradient_x expected %h actual %h", $time,
                            exp_r.gx, o_gradient_x);
                        fail_count++;
                    end
                    if (o_gradient_y !== exp_r.gy) begin
                        $display("%0t: gradient_y expected %h actual %h", $time,
                            exp_r.gy, o_gradient_y);
                        fail_count++;
                    end
                    if (o_magnitude !== exp_r.mag) begin
                        $display("%0t: magnitude expected %0d actual %0d", $time,
                            exp_r.mag, o_magnitude);
                        fail_count++;
                    end
                    if (o_frame_last !== exp_r.last) begin
                        $display("%0t: frame_last expected %b actual %b", $time,
                            exp_r.last, o_frame_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    initial begin
        forever begin
            @(negedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row dir_rows [27];
        t_dir_row none;
        int w, h;
        none = '{default: '0};
        mdl_width = FW_W'(40);
        mdl_height = FH_W'(40);
        for (int i = 0; i < MAX_W; i++) begin
            mdl_upper[i] = '0;
            mdl_middle[i] = '0;
        end
        for (int i = 0; i < 6; i++) mdl_win[i] = '0;
        mdl_col = 0;
        mdl_row = 0;
        // flat frame, strong left edge, strong top edge
        for (int i = 0; i < 27; i++) begin
            dir_rows[i] = none;
            if (i >= 9 && i < 18) dir_rows[i].pixel = ((i - 9) % 3 == 0) ? 8'hFF : 8'h00;
            if (i >= 18) dir_rows[i].pixel = (i < 21) ? 8'hFF : 8'h00;
        end
        dir_rows[8].typed = 1;  dir_rows[8].last = 1;
        dir_rows[17].typed = 1; dir_rows[17].last = 1; dir_rows[17].gx = 17'h18000;
        dir_rows[26].typed = 1; dir_rows[26].last = 1; dir_rows[26].gy = 17'h08000;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        for (int i = 0; i < 27; i++) send_pixel(dir_rows[i].pixel, dir_rows[i].typed, dir_rows[i]);
        wait_drained();

        // size extremes and clamping
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        send_frames(1, 0);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 13'd127);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        send_frames(1, 0);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 13'd64);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        hold_req = 1;
        send_frames(1, 0);
        wait_drained();

        // tall frames cut short by lowering the height mid-frame
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd4096);
        for (int i = 0; i < 12; i++) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, none);
        wait_drained();
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        for (int i = 0; i < 3; i++) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, none);
        wait_drained();
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        for (int i = 0; i < 12; i++) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, none);
        wait_drained();
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        for (int i = 0; i < 3; i++) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, none);
        wait_drained();

        while (rand_items < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0: w = $urandom_range(0, 127);
                1: w = $urandom_range(13, 64);
                default: w = $urandom_range(3, 12);
            endcase
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 8);
            write_reg(REG_FRAME_WIDTH, FH_W'(w));
            write_reg(REG_FRAME_HEIGHT, FH_W'(h));
            send_frames($urandom_range(1, 2), 1);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/sgf_pkg.sv
rtl/sgf_window.sv
rtl/sgf_isqrt.sv
rtl/sobel_gradient_feature.sv
tb/tb_top.sv
